// ===== sv/swm_pkg.sv =====
package swm_pkg;

  localparam int WINDOW_DEF = 11;
  localparam int STAMP_W    = 32;
  localparam int COUNT_W    = 4;
  localparam int AGE_W      = 6;

  typedef struct packed {
    logic               valid;
    logic [STAMP_W-1:0] val;
    logic [AGE_W-1:0]   age;
    logic               up;
    logic               down;
  } swm_link_t;

endpackage

// ===== sv/swm_cell.sv =====
module swm_cell #(
  parameter int WINDOW = swm_pkg::WINDOW_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        load,
  input  logic                        full,
  input  logic [swm_pkg::STAMP_W-1:0] x,
  input  logic [swm_pkg::STAMP_W-1:0] dv,
  input  swm_pkg::swm_link_t          left,
  input  swm_pkg::swm_link_t          right,
  output swm_pkg::swm_link_t          link,
  output logic [swm_pkg::STAMP_W-1:0] del_val
);

  logic                        valid;
  logic [swm_pkg::STAMP_W-1:0] val;
  logic [swm_pkg::AGE_W-1:0]   age;
  logic                        valid_next;
  logic [swm_pkg::STAMP_W-1:0] val_next;
  logic [swm_pkg::AGE_W-1:0]   age_next;
  logic                        below_new;
  logic                        below_del;
  logic                        del;
  logic                        stay;

  // below_new: sorts under the incoming stamp; below_del: under the dropped one
  assign del       = full && valid && (age == swm_pkg::AGE_W'(WINDOW - 1));
  assign below_new = valid && (val < x);
  assign below_del = valid && !del && (!full || (val <= dv));
  assign stay      = valid && !del && (below_new == below_del);
  assign del_val   = del ? val : '0;

  always_comb begin
    link.valid = valid;
    link.val   = val;
    link.age   = age;
    link.up    = below_del && !below_new;
    link.down  = valid && !del && below_new && !below_del;
  end

  always_comb begin
    valid_next = valid || (!full && left.valid);
    if (stay) begin
      val_next = val;
      age_next = age + 1'b1;
    end else if (left.up) begin
      val_next = left.val;
      age_next = left.age + 1'b1;
    end else if (right.down) begin
      val_next = right.val;
      age_next = right.age + 1'b1;
    end else begin
      val_next = x;
      age_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      val <= val_next;
      age <= age_next;
    end
  end

endmodule

// ===== sv/sliding_window_median_top.sv =====
// Running median over the last WINDOW stamps (fewer while filling); an even
// count gives the upper middle value. The window is kept sorted in a chain of
// cells that inserts the new stamp and drops the oldest together, so one
// transaction is taken per cycle unless the input stalls, and its result is
// registered. The input stalls only while a result is held on a stalled output
// and the next one is already waiting. No clearing pass is needed after reset.
module sliding_window_median_top #(
  parameter int WINDOW = swm_pkg::WINDOW_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [swm_pkg::STAMP_W-1:0] stamp,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [swm_pkg::STAMP_W-1:0] median_stamp,
  output logic [swm_pkg::COUNT_W-1:0] held_count
);

  localparam int CW = $clog2(WINDOW + 1);
  localparam int AW = (WINDOW > 1) ? $clog2(WINDOW) : 1;

  swm_pkg::swm_link_t          links [WINDOW];
  swm_pkg::swm_link_t          lefts [WINDOW];
  swm_pkg::swm_link_t          rights[WINDOW];
  logic [swm_pkg::STAMP_W-1:0] del_vals[WINDOW];
  logic [swm_pkg::STAMP_W-1:0] dv;
  logic [CW-1:0]               cnt;
  logic                        full;
  logic                        load;
  logic                        pend;
  logic                        slot_free;

  assign full      = (cnt == CW'(WINDOW));
  assign slot_free = !(out_valid && out_stall);
  assign in_stall  = pend && !slot_free;
  assign load      = in_valid && !in_stall;

  always_comb begin
    dv = '0;
    for (int i = 0; i < WINDOW; i++) begin
      dv = dv | del_vals[i];
    end
  end

  genvar g;
  generate
    for (g = 0; g < WINDOW; g++) begin : g_cell
      if (g == 0) begin : g_first
        // left of the first cell always counts as filled
        assign lefts[g] = '{valid: 1'b1, default: '0};
      end else begin : g_mid_l
        assign lefts[g] = links[g-1];
      end
      if (g == WINDOW - 1) begin : g_last
        assign rights[g] = '0;
      end else begin : g_mid_r
        assign rights[g] = links[g+1];
      end
      swm_cell #(
        .WINDOW(WINDOW)
      ) u_cell (
        .clk     (clk),
        .rst     (rst),
        .load    (load),
        .full    (full),
        .x       (stamp),
        .dv      (dv),
        .left    (lefts[g]),
        .right   (rights[g]),
        .link    (links[g]),
        .del_val (del_vals[g])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (load && !full) begin
        cnt <= cnt + 1'b1;
      end
      if (load) begin
        pend <= 1'b1;
      end else if (slot_free) begin
        pend <= 1'b0;
      end
      if (pend && slot_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pend && slot_free) begin
      median_stamp <= links[AW'(cnt >> 1)].val;
      held_count   <= swm_pkg::COUNT_W'(cnt);
    end
  end

endmodule

// ===== sv/swm_checker.sv =====
module swm_checker #(
  parameter int WINDOW = swm_pkg::WINDOW_DEF
) (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic [swm_pkg::STAMP_W-1:0] stamp,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [swm_pkg::STAMP_W-1:0] median_stamp,
  input logic [swm_pkg::COUNT_W-1:0] held_count
);

  // input back-pressure only comes from a held result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without output back-pressure");

  // out_valid follows every accepted transaction through the output register
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |-> ##2 out_valid)
    else $error("result missing after accepted transaction");

  a_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (held_count != '0) &&
                  (held_count <= swm_pkg::COUNT_W'(WINDOW)))
    else $error("held_count out of range");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(median_stamp) &&
                                  $stable(held_count)))
    else $error("stalled result changed");

  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind sliding_window_median_top swm_checker #(.WINDOW(WINDOW)) u_swm_checker (.*);
